// ===== sv/lbvs_pkg.sv =====
// Package with the types, constants and helpers of the linear blend vertex skinning block.
`timescale 1ns / 1ps

package lbvs_pkg;

  // Request kinds carried on the input tuser.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_BLEND = 1'b1;

  // Field widths of one input request.
  localparam int JOINT_W = 5;
  localparam int COEF_IDX_W = 4;
  localparam int WORD_W = 32;
  localparam int WEIGHT_W = 17;

  // Bit offsets inside the input tdata, lowest field first.
  localparam int JOINT_LSB = 0;
  localparam int COEF_IDX_LSB = JOINT_LSB + JOINT_W;
  localparam int COEF_VAL_LSB = COEF_IDX_LSB + COEF_IDX_W;
  localparam int POS_X_LSB = COEF_VAL_LSB + WORD_W;
  localparam int POS_Y_LSB = POS_X_LSB + WORD_W;
  localparam int POS_Z_LSB = POS_Y_LSB + WORD_W;
  localparam int WEIGHT_LSB = POS_Z_LSB + WORD_W;
  localparam int IN_FIELDS_W = WEIGHT_LSB + WEIGHT_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * WORD_W;

  // Matrix layout: three rows of four coefficients.
  localparam int COEFS_PER_JOINT = 12;
  localparam logic [1:0] COL_OFFSET = 2'd3;

  // Sequencer step limits.
  localparam logic [3:0] STEP_READ_END = 4'd11;
  localparam logic [3:0] STEP_MAT_END = 4'd13;
  localparam logic [3:0] STEP_WGT_END = 4'd3;
  localparam logic [3:0] STEP_WGT_MUL_END = 4'd2;

  // Weights are unsigned Q1.16, so the blended sum carries sixteen extra fraction bits.
  localparam int WEIGHT_FRAC = 16;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (WEIGHT_FRAC - 1);
  localparam logic signed [63:0] ACC_LIMIT = 64'sd1 <<< 62;
  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAT,
    S_WGT,
    S_EMIT
  } state_t;

  // Per-cycle datapath enables decoded from the sequencer.
  typedef struct packed {
    logic mem_wr;
    logic mem_rd;
    logic mat_mul;
    logic row_add;
    logic wgt_mul;
    logic acc_upd;
    logic emit_go;
  } ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > WORD_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < WORD_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > WORD_MAX) || (v < WORD_MIN);
  endfunction

endpackage

// ===== sv/linear_blend_vertex_skinning_top.sv =====
// Top level of the linear blend vertex skinning block: matrix store, sequencer and datapath.
`timescale 1ns / 1ps

// Channel | Dir | Ports                         | Contents
// in_     | in  | tvalid tready tdata tuser tlast | load or blend request
// out_    | out | tvalid tready tdata tuser       | skinned vertex and saturation flag
//
// A load request writes one coefficient into the matrix store if joint and index are
// in range. A blend request runs through S_MAT and S_WGT (and S_EMIT if it closes the
// vertex); its length is set by the single multiplier, which does nine matrix products
// and three weight products in turn, and by the single read port of the matrix store,
// which delivers one coefficient per cycle. in_tready is high only between requests.
// Reset clears the sequencer, the accumulators and the sticky saturation bit; the matrix
// store is not cleared and must be loaded before use.
// A result waits in the output register while the next request is taken; only a second
// vertex end holds the sequencer until the first result has been taken.

module linear_blend_vertex_skinning_top #(
  parameter int MAX_JOINTS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // joint_index, coef_index, coef_value, pos_x, pos_y, pos_z, weight, zero fill
  input  logic [lbvs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // req_type
  input  logic                              in_tuser,
  // last_joint
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_x, out_y, out_z
  output logic [lbvs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // saturated
  output logic                              out_tuser
);

  localparam int DEPTH = MAX_JOINTS * lbvs_pkg::COEFS_PER_JOINT;
  localparam int AW = $clog2(DEPTH);

  // Input fields.
  logic [lbvs_pkg::JOINT_W-1:0]    in_joint;
  logic [lbvs_pkg::COEF_IDX_W-1:0] in_coef_idx;
  logic [31:0]                     in_coef_val;
  logic [31:0]                     in_pos_x;
  logic [31:0]                     in_pos_y;
  logic [31:0]                     in_pos_z;
  logic [lbvs_pkg::WEIGHT_W-1:0]   in_weight;

  assign in_joint    = in_tdata[lbvs_pkg::JOINT_LSB +: lbvs_pkg::JOINT_W];
  assign in_coef_idx = in_tdata[lbvs_pkg::COEF_IDX_LSB +: lbvs_pkg::COEF_IDX_W];
  assign in_coef_val = in_tdata[lbvs_pkg::COEF_VAL_LSB +: 32];
  assign in_pos_x    = in_tdata[lbvs_pkg::POS_X_LSB +: 32];
  assign in_pos_y    = in_tdata[lbvs_pkg::POS_Y_LSB +: 32];
  assign in_pos_z    = in_tdata[lbvs_pkg::POS_Z_LSB +: 32];
  assign in_weight   = in_tdata[lbvs_pkg::WEIGHT_LSB +: lbvs_pkg::WEIGHT_W];

  // Sequencer state.
  lbvs_pkg::state_t state_r, state_nxt;
  logic [3:0]       step_r, step_nxt;
  lbvs_pkg::ctl_t   ctl;

  // Request registers.
  logic [AW-1:0]                 base_r;
  logic signed [31:0]            pos_x_r, pos_y_r, pos_z_r;
  logic [lbvs_pkg::WEIGHT_W-1:0] weight_r;
  logic                          last_r;

  // Datapath registers.
  logic [31:0]        mem [0:DEPTH-1];
  logic [31:0]        mem_q_r;
  logic signed [63:0] prod_r;
  logic               const_r;
  logic signed [63:0] rowsum_r;
  logic signed [31:0] t_r [0:2];
  logic signed [63:0] acc_r [0:2];
  logic               sticky_r;
  logic               out_valid_r;
  logic [lbvs_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic               out_sat_r;

  logic accept;
  logic is_load;
  logic joint_ok;
  logic coef_ok;
  logic [31:0] base_lin;
  logic [31:0] wr_lin;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [3:0] idx1;
  logic [3:0] idx2;

  assign in_tready = (state_r == lbvs_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_load   = (in_tuser == lbvs_pkg::REQ_LOAD);
  assign joint_ok  = (32'(in_joint) < 32'(MAX_JOINTS));
  assign coef_ok   = (in_coef_idx < 4'(lbvs_pkg::COEFS_PER_JOINT));
  assign base_lin  = 32'(in_joint) * 32'(lbvs_pkg::COEFS_PER_JOINT);
  assign wr_lin    = base_lin + 32'(in_coef_idx);
  assign wr_addr   = wr_lin[AW-1:0];
  assign rd_addr   = base_r + AW'(step_r);

  // Step k reads coefficient k, step k+1 multiplies it, step k+2 adds it to the row sum.
  assign idx1 = step_r - 4'd1;
  assign idx2 = step_r - 4'd2;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbvs_pkg::S_IDLE: begin
        if (accept && !is_load) begin
          if (joint_ok) begin
            state_nxt = lbvs_pkg::S_MAT;
          end else if (in_tlast) begin
            state_nxt = lbvs_pkg::S_EMIT;
          end
        end
      end
      lbvs_pkg::S_MAT: begin
        if (step_r == lbvs_pkg::STEP_MAT_END) begin
          state_nxt = lbvs_pkg::S_WGT;
        end
      end
      lbvs_pkg::S_WGT: begin
        if (step_r == lbvs_pkg::STEP_WGT_END) begin
          state_nxt = last_r ? lbvs_pkg::S_EMIT : lbvs_pkg::S_IDLE;
        end
      end
      lbvs_pkg::S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = lbvs_pkg::S_IDLE;
        end
      end
      default: state_nxt = lbvs_pkg::S_IDLE;
    endcase
    step_nxt = (state_nxt != state_r) ? 4'd0 : step_r + 4'd1;
  end

  // Datapath enables.
  always_comb begin
    ctl = '0;
    case (state_r)
      lbvs_pkg::S_IDLE: begin
        ctl.mem_wr = accept && is_load && joint_ok && coef_ok;
      end
      lbvs_pkg::S_MAT: begin
        ctl.mem_rd  = (step_r <= lbvs_pkg::STEP_READ_END);
        ctl.mat_mul = (step_r >= 4'd1) && (step_r <= lbvs_pkg::STEP_READ_END + 4'd1);
        ctl.row_add = (step_r >= 4'd2);
      end
      lbvs_pkg::S_WGT: begin
        ctl.wgt_mul = (step_r <= lbvs_pkg::STEP_WGT_MUL_END);
        ctl.acc_upd = (step_r >= 4'd1);
      end
      lbvs_pkg::S_EMIT: begin
        ctl.emit_go = !out_valid_r || out_tready;
      end
      default: ctl = '0;
    endcase
  end

  // Shared multiplier: matrix products in S_MAT, weight products in S_WGT.
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [31:0] pos_sel;

  always_comb begin
    case (idx1[1:0])
      2'd0:    pos_sel = pos_x_r;
      2'd1:    pos_sel = pos_y_r;
      default: pos_sel = pos_z_r;
    endcase
    if (state_r == lbvs_pkg::S_WGT) begin
      mul_a = t_r[0];
      mul_b = $signed({16'd0, weight_r});
    end else begin
      mul_a = $signed(mem_q_r);
      mul_b = {pos_sel[31], pos_sel};
    end
  end

  assign mul_p = mul_a * mul_b;

  // Row sum: products are floored by FRAC_BITS, the fourth column is added as it is.
  logic signed [63:0] term;
  logic signed [63:0] row_full;
  logic               row_ovf;

  assign term     = const_r ? prod_r : (prod_r >>> FRAC_BITS);
  assign row_full = ((idx2[1:0] == 2'd0) ? 64'sd0 : rowsum_r) + term;
  assign row_ovf  = lbvs_pkg::ovf32(row_full);

  // Accumulator update with saturation at plus or minus 2^62.
  logic signed [63:0] acc_sum;
  logic signed [63:0] acc_sat;
  logic               acc_ovf;

  always_comb begin
    acc_sum = acc_r[0] + prod_r;
    acc_ovf = 1'b0;
    acc_sat = acc_sum;
    if (acc_sum > lbvs_pkg::ACC_LIMIT) begin
      acc_sat = lbvs_pkg::ACC_LIMIT;
      acc_ovf = 1'b1;
    end else if (acc_sum < -lbvs_pkg::ACC_LIMIT) begin
      acc_sat = -lbvs_pkg::ACC_LIMIT;
      acc_ovf = 1'b1;
    end
  end

  // Output rounding: add one half, drop the weight fraction, clamp to 32 bits.
  logic signed [63:0] rnd [0:2];
  logic [2:0]         out_ovf;
  logic [lbvs_pkg::OUT_TDATA_W-1:0] out_pack;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (acc_r[i] + lbvs_pkg::ROUND_HALF) >>> lbvs_pkg::WEIGHT_FRAC;
      out_ovf[i] = lbvs_pkg::ovf32(rnd[i]);
      out_pack[i*32 +: 32] = lbvs_pkg::sat32(rnd[i]);
    end
  end

  // Matrix store: one write port for loads, one registered read port for blends.
  always_ff @(posedge clk) begin
    if (ctl.mem_wr) begin
      mem[wr_addr] <= in_coef_val;
    end
    if (ctl.mem_rd) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept && !is_load) begin
      base_r   <= base_lin[AW-1:0];
      pos_x_r  <= $signed(in_pos_x);
      pos_y_r  <= $signed(in_pos_y);
      pos_z_r  <= $signed(in_pos_z);
      weight_r <= in_weight;
      last_r   <= in_tlast;
    end
    if (ctl.mat_mul) begin
      const_r <= (idx1[1:0] == lbvs_pkg::COL_OFFSET);
      if (idx1[1:0] == lbvs_pkg::COL_OFFSET) begin
        prod_r <= 64'($signed(mem_q_r));
      end else begin
        prod_r <= mul_p[63:0];
      end
    end else if (ctl.wgt_mul) begin
      prod_r <= mul_p[63:0];
    end
    if (ctl.row_add) begin
      rowsum_r <= row_full;
    end
    // Row results shift in from the top; weight products take them from the bottom.
    if ((ctl.row_add && (idx2[1:0] == lbvs_pkg::COL_OFFSET)) || ctl.wgt_mul) begin
      t_r[0] <= t_r[1];
      t_r[1] <= t_r[2];
      t_r[2] <= lbvs_pkg::sat32(row_full);
    end
    if (ctl.emit_go) begin
      out_data_r <= out_pack;
      out_sat_r  <= sticky_r || (|out_ovf);
    end
  end

  // Control state, accumulators and sticky flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbvs_pkg::S_IDLE;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
      sticky_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= 64'sd0;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (ctl.emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.emit_go) begin
        sticky_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          acc_r[i] <= 64'sd0;
        end
      end else begin
        if ((ctl.row_add && (idx2[1:0] == lbvs_pkg::COL_OFFSET) && row_ovf) ||
            (ctl.acc_upd && acc_ovf)) begin
          sticky_r <= 1'b1;
        end
        // The three sums rotate so that the one being updated is always at the bottom.
        if (ctl.acc_upd) begin
          acc_r[0] <= acc_r[1];
          acc_r[1] <= acc_r[2];
          acc_r[2] <= acc_sat;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

  // A new result is only ever loaded from the emit step.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == lbvs_pkg::S_EMIT))
    else $error("result appeared without an emit step");

  // A blend that closes the vertex goes on to emit its result.
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbvs_pkg::S_WGT && step_r == lbvs_pkg::STEP_WGT_END && last_r)
      |=> state_r == lbvs_pkg::S_EMIT)
    else $error("vertex end did not reach the emit step");

  // Emitting a result leaves the accumulators and the sticky flag clear.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit_go |=> (acc_r[0] == 64'sd0 && acc_r[1] == 64'sd0 &&
                     acc_r[2] == 64'sd0 && !sticky_r))
    else $error("accumulators not cleared after a result");

  // The matrix store is never written while a blend is in flight.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbvs_pkg::S_MAT || state_r == lbvs_pkg::S_WGT) |-> !ctl.mem_wr)
    else $error("matrix store written during a blend");

endmodule

// ===== test/tb.sv =====
// Self-checking stream testbench for the linear blend vertex skinning block.
`timescale 1ns / 1ps

// The testbench loads a skinning matrix for every joint and then sends blend requests,
// one per joint that moves a vertex. Each accepted request goes through a predictor
// that keeps its own copy of the matrix store, the three blend sums and the sticky
// saturation bit. The predictor queues one expected skinned vertex for every request
// that closes a vertex. A checker process takes each result the block hands over and
// compares it field by field with the oldest queued vertex.
//
// Stimulus, in order:
//   - matrix loads for all 32 joints. Joint 0 holds the identity, joint 30 a pure
//     translation to the word limits, joint 31 coefficients at the word extremes, and
//     the rest random rotations and translations.
//   - loads with a coefficient index above eleven. The block must ignore these.
//   - directed blends: exact identity, the position extremes, zero weight, rounding
//     at half an LSB, a weight above one, clamping of a row sum, the translation to
//     the word limits, and a two-joint vertex.
//   - a long output stall while vertices keep arriving. The block fills up and holds
//     off its input. The sender then waits until every result is back.
//   - one long vertex at the largest weight that carries the blend sums far past the
//     output range.
//   - random traffic: mostly well-formed vertices, plus stray loads (some of them out
//     of range) and vertices with arbitrary weights.
//   - a last stretch with no idling on either side.
// Both sides idle in random bursts, except in the long vertex and the last stretch.
// Inputs change on the falling edge and outputs are sampled on the rising edge, so no
// result depends on event order within a time step.

module tb;

  localparam int JOINTS = 32;
  localparam int FRAC = 16;
  localparam int ID_JOINT = 0;
  localparam int SAT_JOINT = 30;
  localparam int EDGE_JOINT = 31;
  localparam logic [lbvs_pkg::WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
  localparam logic [lbvs_pkg::WEIGHT_W-1:0] WEIGHT_TOP = 17'h1_ffff;
  localparam logic signed [31:0] WORD_TOP = 32'sh7fff_ffff;
  localparam logic signed [31:0] WORD_BOTTOM = 32'sh8000_0000;
  localparam longint WORD_HI = 64'sd2147483647;
  localparam longint WORD_LO = -64'sd2147483648;
  localparam longint ACC_CAP = 64'sd1 <<< 62;
  localparam longint HALF_LSB = 64'sd1 <<< 15;
  // The longest legal quiet stretch is the deliberate output stall of HOLD_CYCLES, so
  // the watchdog limit is set well above that.
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_PRINTED = 40;
  // Each contribution adds up to about 2^48 to a blend sum, so this many of them at the
  // largest weight carry the sums to about 2^53.
  localparam int LONG_RUN_LEN = 40;

  // One input request, with its fields at the widths the block uses.
  typedef struct {
    logic                               req;
    logic [lbvs_pkg::JOINT_W-1:0]       joint;
    logic [lbvs_pkg::COEF_IDX_W-1:0]    coef_idx;
    logic signed [lbvs_pkg::WORD_W-1:0] coef_val;
    logic signed [lbvs_pkg::WORD_W-1:0] pos_x;
    logic signed [lbvs_pkg::WORD_W-1:0] pos_y;
    logic signed [lbvs_pkg::WORD_W-1:0] pos_z;
    logic [lbvs_pkg::WEIGHT_W-1:0]      weight;
    logic                               last;
  } blend_req_t;

  // One skinned vertex, as the block should hand it over.
  typedef struct {
    logic signed [31:0] coord [3];
    logic               sat;
  } skinned_vertex_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [lbvs_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             in_tlast = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [lbvs_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  // Predictor state: the matrix store, the three blend sums and the sticky bit.
  logic signed [31:0] coef_store [JOINTS*lbvs_pkg::COEFS_PER_JOINT];
  longint             blend_sum [3] = '{0, 0, 0};
  bit                 vertex_sat = 1'b0;
  skinned_vertex_t    skinned_q [$];

  // Idling controls. The main sequence writes the flags and hold_seq; the sink writes the rest.
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int hold_seq = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_left = 0;

  int err_count = 0;
  int requests_sent = 0;
  int vertices_checked = 0;
  int sat_seen = 0;
  int quiet_cycles = 0;

  always #4 clk = ~clk;

  linear_blend_vertex_skinning_top #(
    .MAX_JOINTS(JOINTS),
    .FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Clamps a value to the signed 32-bit range and records whether it had to.
  function automatic longint clamp_word(input longint v, inout bit sat);
    if (v > WORD_HI) begin
      sat = 1'b1;
      return WORD_HI;
    end
    if (v < WORD_LO) begin
      sat = 1'b1;
      return WORD_LO;
    end
    return v;
  endfunction

  // Applies one accepted request to the predictor state. When the request closes a
  // vertex, the expected skinned vertex is queued.
  function automatic void skin_predict(input blend_req_t r);
    longint          p [3];
    longint          t;
    longint          a;
    longint          w;
    int              base;
    int              row;
    int              k;
    skinned_vertex_t v;
    if (r.req == lbvs_pkg::REQ_LOAD) begin
      if (r.coef_idx < lbvs_pkg::COEFS_PER_JOINT && r.joint < JOINTS) begin
        coef_store[r.joint * lbvs_pkg::COEFS_PER_JOINT + r.coef_idx] = r.coef_val;
      end
      return;
    end
    if (r.joint < JOINTS) begin
      base = r.joint * lbvs_pkg::COEFS_PER_JOINT;
      p[0] = longint'(r.pos_x);
      p[1] = longint'(r.pos_y);
      p[2] = longint'(r.pos_z);
      w = longint'(r.weight);
      for (row = 0; row < 3; row++) begin
        // Each product is floored back to the coefficient scale before the sum.
        t = longint'(coef_store[base + 4*row + 3]);
        for (k = 0; k < 3; k++) begin
          t += (longint'(coef_store[base + 4*row + k]) * p[k]) >>> FRAC;
        end
        t = clamp_word(t, vertex_sat);
        a = blend_sum[row] + t * w;
        if (a > ACC_CAP) begin
          a = ACC_CAP;
          vertex_sat = 1'b1;
        end else if (a < -ACC_CAP) begin
          a = -ACC_CAP;
          vertex_sat = 1'b1;
        end
        blend_sum[row] = a;
      end
    end
    if (!r.last) begin
      return;
    end
    for (row = 0; row < 3; row++) begin
      // Drop the 16 weight fraction bits, rounding half up.
      t = (blend_sum[row] + HALF_LSB) >>> lbvs_pkg::WEIGHT_FRAC;
      v.coord[row] = 32'(clamp_word(t, vertex_sat));
      blend_sum[row] = 0;
    end
    v.sat = vertex_sat;
    vertex_sat = 1'b0;
    skinned_q.insert(skinned_q.size(), v);
  endfunction

  function automatic int rand_signed(input int half);
    return int'($urandom_range(0, 2 * half)) - half;
  endfunction

  // Every field is filled at random, so that loads carry stray positions and weights,
  // and blends carry stray coefficient fields.
  function automatic blend_req_t junk_request();
    blend_req_t r;
    r.req = 1'($urandom);
    r.joint = lbvs_pkg::JOINT_W'($urandom);
    r.coef_idx = lbvs_pkg::COEF_IDX_W'($urandom);
    r.coef_val = $urandom;
    r.pos_x = $urandom;
    r.pos_y = $urandom;
    r.pos_z = $urandom;
    r.weight = lbvs_pkg::WEIGHT_W'($urandom);
    r.last = 1'($urandom);
    return r;
  endfunction

  function automatic blend_req_t make_load(input int joint, input int idx,
                                           input logic signed [31:0] val);
    blend_req_t r;
    r = junk_request();
    r.req = lbvs_pkg::REQ_LOAD;
    r.joint = lbvs_pkg::JOINT_W'(joint);
    r.coef_idx = lbvs_pkg::COEF_IDX_W'(idx);
    r.coef_val = val;
    return r;
  endfunction

  function automatic blend_req_t make_blend(input int joint, input logic signed [31:0] x,
                                            input logic signed [31:0] y,
                                            input logic signed [31:0] z,
                                            input logic [lbvs_pkg::WEIGHT_W-1:0] w,
                                            input logic last);
    blend_req_t r;
    r = junk_request();
    r.req = lbvs_pkg::REQ_BLEND;
    r.joint = lbvs_pkg::JOINT_W'(joint);
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    r.weight = w;
    r.last = last;
    return r;
  endfunction

  // Matrix contents: the identity, a translation to the word limits, the word
  // extremes, or a random rotation and translation (now and then any word at all).
  function automatic logic signed [31:0] pick_coef(input int joint, input int idx);
    if (joint == ID_JOINT) begin
      return (idx == 0 || idx == 5 || idx == 10) ? 32'sh0001_0000 : 32'sh0;
    end
    if (joint == SAT_JOINT) begin
      return (idx == 3) ? WORD_TOP : (idx == 7) ? WORD_BOTTOM : 32'sh0;
    end
    if (joint == EDGE_JOINT) begin
      return idx[0] ? WORD_BOTTOM : WORD_TOP;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom;
    end
    return (idx % 4 == 3) ? rand_signed(1 << 24) : rand_signed(1 << 17);
  endfunction

  function automatic logic signed [31:0] pick_pos();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom;
    end
    return rand_signed(1 << 26);
  endfunction

  // Sends one request. The task is entered at a falling edge and returns at the
  // falling edge after the block has taken the request. tvalid stays high on return,
  // so that back-to-back requests are not interrupted.
  task automatic send_item(input blend_req_t r);
    logic [lbvs_pkg::IN_TDATA_W-1:0] d;
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    d = '0;
    d[lbvs_pkg::JOINT_LSB +: lbvs_pkg::JOINT_W] = r.joint;
    d[lbvs_pkg::COEF_IDX_LSB +: lbvs_pkg::COEF_IDX_W] = r.coef_idx;
    d[lbvs_pkg::COEF_VAL_LSB +: lbvs_pkg::WORD_W] = r.coef_val;
    d[lbvs_pkg::POS_X_LSB +: lbvs_pkg::WORD_W] = r.pos_x;
    d[lbvs_pkg::POS_Y_LSB +: lbvs_pkg::WORD_W] = r.pos_y;
    d[lbvs_pkg::POS_Z_LSB +: lbvs_pkg::WORD_W] = r.pos_z;
    d[lbvs_pkg::WEIGHT_LSB +: lbvs_pkg::WEIGHT_W] = r.weight;
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= r.req;
    in_tlast <= r.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    skin_predict(r);
    requests_sent++;
    @(negedge clk);
  endtask

  // Lowers tvalid and waits until every queued vertex has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (skinned_q.size() != 0) @(negedge clk);
  endtask

  // A well-formed vertex: one to four joints that share a bind position. The weights
  // usually add up to one. About one vertex in ten gets arbitrary 17-bit weights.
  task automatic send_random_vertex();
    int                  n;
    int                  k;
    int                  left;
    int                  w;
    logic signed [31:0]  x;
    logic signed [31:0]  y;
    logic signed [31:0]  z;
    bit                  wild;
    n = $urandom_range(1, 4);
    left = WEIGHT_ONE;
    x = pick_pos();
    y = pick_pos();
    z = pick_pos();
    wild = ($urandom_range(0, 9) == 0);
    for (k = 0; k < n; k++) begin
      w = (k == n - 1) ? left : $urandom_range(0, left);
      left -= w;
      if (wild) begin
        w = $urandom_range(0, WEIGHT_TOP);
      end
      send_item(make_blend($urandom_range(0, JOINTS - 1), x, y, z,
                           lbvs_pkg::WEIGHT_W'(w), k == n - 1));
    end
  endtask

  task automatic test_load_matrices();
    int j;
    int i;
    for (j = 0; j < JOINTS; j++) begin
      for (i = 0; i < lbvs_pkg::COEFS_PER_JOINT; i++) begin
        send_item(make_load(j, i, pick_coef(j, i)));
      end
    end
  endtask

  // Coefficient indexes 12 to 15 do not exist. The identity of joint 0 must survive
  // these loads, and the directed blends that follow check that it did.
  task automatic test_ignored_loads();
    int i;
    for (i = lbvs_pkg::COEFS_PER_JOINT; i < 16; i++) begin
      send_item(make_load(ID_JOINT, i, $urandom));
    end
  endtask

  task automatic test_blend_edges();
    // The identity with weight one must return the bind position exactly.
    send_item(make_blend(ID_JOINT, 32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000,
                         WEIGHT_ONE, 1'b1));
    send_item(make_blend(ID_JOINT, WORD_TOP, WORD_BOTTOM, 32'sh0, WEIGHT_ONE, 1'b1));
    // A zero weight blends to the origin.
    send_item(make_blend(ID_JOINT, $urandom, $urandom, $urandom, '0, 1'b1));
    // With the smallest weight, the rounding falls exactly on half an LSB and just
    // below it.
    send_item(make_blend(ID_JOINT, 32'sh8000, -32'sh8000, -32'sh8001, 17'd1, 1'b1));
    // A weight above one is used as given, so the output clamps.
    send_item(make_blend(ID_JOINT, WORD_TOP, WORD_BOTTOM, 32'sh4000_0000,
                         WEIGHT_TOP, 1'b1));
    // Extreme coefficients times extreme positions clamp each row sum.
    send_item(make_blend(EDGE_JOINT, WORD_TOP, WORD_TOP, WORD_TOP, WEIGHT_ONE, 1'b1));
    send_item(make_blend(EDGE_JOINT, WORD_BOTTOM, WORD_TOP, 32'sh0, WEIGHT_ONE, 1'b1));
    // The translation reaches both word limits without clamping.
    send_item(make_blend(SAT_JOINT, $urandom, $urandom, $urandom, WEIGHT_ONE, 1'b1));
    // A two-joint vertex split evenly between the identity and the extremes.
    send_item(make_blend(ID_JOINT, 32'sh0000_0123, 32'sh0100_0000, -32'sh0000_8000,
                         17'h0_8000, 1'b0));
    send_item(make_blend(EDGE_JOINT, 32'sh0000_0123, 32'sh0100_0000, -32'sh0000_8000,
                         17'h0_8000, 1'b1));
  endtask

  // The receiver holds off for a long stretch while vertices keep arriving. Then the
  // sender pauses until all results are back.
  task automatic test_output_stall();
    int k;
    hold_seq++;
    for (k = 0; k < 12; k++) begin
      send_random_vertex();
    end
    wait_drained();
  endtask

  // One long vertex on the translation joint at the largest weight. Row 0 grows far
  // above and row 1 far below the output range, so both clamp; row 2 stays at zero.
  task automatic test_long_vertex();
    int k;
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    for (k = 0; k < LONG_RUN_LEN; k++) begin
      send_item(make_blend(SAT_JOINT, $urandom, $urandom, $urandom, WEIGHT_TOP,
                           k == LONG_RUN_LEN - 1));
    end
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  // Mostly whole vertices. Some requests are stray coefficient loads, a few of them
  // out of range, and some are single joints with arbitrary weight and end flag.
  task automatic test_random_traffic(input int count);
    int         stop_at;
    int         pick;
    int         j;
    int         i;
    blend_req_t r;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        j = $urandom_range(0, JOINTS - 1);
        i = $urandom_range(0, 15);
        send_item(make_load(j, i, (i < lbvs_pkg::COEFS_PER_JOINT) ? pick_coef(j, i)
                                                                  : $urandom));
      end else if (pick == 2) begin
        r = make_blend($urandom_range(0, JOINTS - 1), pick_pos(), pick_pos(), pick_pos(),
                       lbvs_pkg::WEIGHT_W'($urandom), 1'($urandom));
        send_item(r);
      end else begin
        send_random_vertex();
      end
    end
  endtask

  task automatic test_steady_stream();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    test_random_traffic(150);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // Only the first few mismatches are printed, so that a broken block does not flood
    // the log. All of them are counted.
    if (err_count < MAX_PRINTED) begin
      $display("tb: vertex %0d %s: got %h, want %h", vertices_checked, what, got, want);
    end
    err_count++;
  endtask

  // Result receiver. It idles in random bursts and, on request, holds off for
  // HOLD_CYCLES.
  always @(negedge clk) begin
    if (hold_seq != hold_ack) begin
      hold_ack <= hold_seq;
      hold_left <= HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compares each result with the oldest expected vertex.
  always @(posedge clk) begin : result_check
    skinned_vertex_t want;
    int              c;
    if (rst_n && out_tvalid && out_tready) begin
      if (skinned_q.size() == 0) begin
        report_mismatch("result with no vertex pending, x", out_tdata[31:0], '0);
      end else begin
        want = skinned_q.pop_front();
        for (c = 0; c < 3; c++) begin
          if (out_tdata[32*c +: 32] !== want.coord[c]) begin
            report_mismatch($sformatf("coordinate %0d", c), out_tdata[32*c +: 32],
                            want.coord[c]);
          end
        end
        if (out_tuser !== want.sat) begin
          report_mismatch("saturated flag", 32'(out_tuser), 32'(want.sat));
        end
      end
      if (out_tuser === 1'b1) begin
        sat_seen++;
      end
      vertices_checked++;
    end
  end

  // Ends the run if no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: no progress for %0d cycles, %0d vertices outstanding",
               WATCHDOG_LIMIT, skinned_q.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_load_matrices();
    test_ignored_loads();
    test_blend_edges();
    test_output_stall();
    test_long_vertex();
    test_random_traffic(280);
    test_steady_stream();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d requests sent, %0d vertices checked, %0d of them saturated",
             requests_sent, vertices_checked, sat_seen);
    $display("tb: covered matrix loads, extremes, rounding, stalls and wide blend sums");
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
